// File: rtl/core/touch_gesture_classifier_macros.svh
// Assertion macros for the touch gesture classifier.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define TGC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TGC_ASSERT(lbl, clk, rst_n, prop, msg)

`define TGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define TGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/tgc_pkg.sv
// Shared types, constants and sensor tables of the touch gesture classifier.
// No dependencies; used by every other RTL file except the macro header.
`default_nettype none

package tgc_pkg;

	localparam int NUM_SENSORS     = 24;
	localparam int NUM_FACES       = 6;
	localparam int NUM_CORNERS     = 8;
	localparam int NUM_RESET_FACES = 2;
	localparam int RING_LEN        = 8;
	localparam int FACE_LEN        = 4;
	localparam int CORNER_LEN      = 3;

	localparam int CNT_W   = 8;
	localparam int THR_W   = 7;
	localparam int FACE_W  = 3;
	localparam int ACT_W   = 3;
	localparam int SIDX_W  = $clog2(NUM_SENSORS);
	localparam int REGI_W  = 1;

	typedef logic signed [CNT_W-1:0] count_t;
	typedef logic [THR_W-1:0]        thr_t;
	typedef logic [FACE_W-1:0]       face_t;
	typedef logic [SIDX_W-1:0]       sidx_t;
	typedef logic [REGI_W-1:0]       regi_t;
	typedef logic [NUM_SENSORS-1:0]  sens_vec_t;

	localparam count_t RUN_MAX = 8'sh7F;
	localparam count_t RUN_MIN = 8'sh80;
	localparam count_t RUN_UP  = 8'sh01;
	localparam count_t RUN_DN  = 8'shFF;

	localparam thr_t THR_RESET     = 7'd30;
	localparam thr_t PREVIEW_RESET = 7'd1;

	localparam regi_t REG_DETECT_THR  = 1'b0;
	localparam regi_t REG_PREVIEW_THR = 1'b1;

	localparam logic [RING_LEN-1:0] PAT_CW_A  = 8'h11;
	localparam logic [RING_LEN-1:0] PAT_CW_B  = 8'h44;
	localparam logic [RING_LEN-1:0] PAT_CCW_A = 8'h22;
	localparam logic [RING_LEN-1:0] PAT_CCW_B = 8'h88;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE     = 3'd0,
		ACT_RESET    = 3'd1,
		ACT_SCRAMBLE = 3'd2,
		ACT_UNDO     = 3'd3,
		ACT_ROTATE   = 3'd4
	} action_t;

	typedef struct packed {
		logic  hit;
		face_t face;
		logic  ccw;
	} rot_t;

	typedef struct packed {
		action_t action;
		face_t   rot_face;
		logic    rot_ccw;
		logic    pre_valid;
		face_t   pre_face;
		logic    pre_ccw;
	} result_t;

	localparam sidx_t ROT_RING [NUM_FACES][RING_LEN] = '{
		'{5'd1,  5'd0,  5'd6,  5'd7,  5'd22, 5'd23, 5'd14, 5'd15},
		'{5'd18, 5'd19, 5'd4,  5'd6,  5'd8,  5'd9,  5'd15, 5'd13},
		'{5'd19, 5'd17, 5'd21, 5'd22, 5'd11, 5'd8,  5'd0,  5'd2},
		'{5'd17, 5'd16, 5'd12, 5'd14, 5'd10, 5'd11, 5'd7,  5'd5},
		'{5'd16, 5'd18, 5'd3,  5'd1,  5'd9,  5'd10, 5'd23, 5'd20},
		'{5'd20, 5'd21, 5'd5,  5'd4,  5'd2,  5'd3,  5'd13, 5'd12}
	};

	localparam sidx_t CORNER_SET [NUM_CORNERS][CORNER_LEN] = '{
		'{5'd10, 5'd23, 5'd14}, '{5'd11, 5'd7,  5'd22},
		'{5'd9,  5'd15, 5'd1},  '{5'd8,  5'd0,  5'd6},
		'{5'd18, 5'd3,  5'd13}, '{5'd19, 5'd4,  5'd2},
		'{5'd16, 5'd12, 5'd20}, '{5'd17, 5'd21, 5'd5}
	};

	localparam sidx_t FACE_SET [NUM_RESET_FACES][FACE_LEN] = '{
		'{5'd14, 5'd15, 5'd12, 5'd13},
		'{5'd1,  5'd0,  5'd3,  5'd2}
	};

	// unique opposite-pair match over the six face rings
	function automatic rot_t find_rotation(input sens_vec_t hit);
		logic [RING_LEN-1:0]  pat;
		logic [NUM_FACES-1:0] match;
		logic [NUM_FACES-1:0] ccw;
		rot_t                 r;
		match = '0;
		ccw   = '0;
		r     = '0;
		for (int f = 0; f < NUM_FACES; f++) begin
			for (int i = 0; i < RING_LEN; i++) begin
				pat[i] = hit[ROT_RING[f][i]];
			end
			ccw[f]   = (pat == PAT_CCW_A) || (pat == PAT_CCW_B);
			match[f] = (pat == PAT_CW_A) || (pat == PAT_CW_B) || ccw[f];
		end
		if ((match != '0) && ((match & (match - 1'b1)) == '0)) begin
			r.hit = 1'b1;
			for (int f = 0; f < NUM_FACES; f++) begin
				if (match[f]) begin
					r.face = FACE_W'(f);
					r.ccw  = ccw[f];
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/tgc_stream_if.sv
// Valid/ready channel interfaces of the touch gesture classifier: scan in, result out.
// Depends on tgc_pkg for field widths.
`default_nettype none

interface tgc_scan_if import tgc_pkg::*;;
	logic      valid;
	logic      ready;
	sens_vec_t sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface tgc_result_if import tgc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	face_t            rotation_face;
	logic             rotation_ccw;
	logic             preview_valid;
	face_t            preview_face;
	logic             preview_ccw;

	modport source (output valid, output action, output rotation_face, output rotation_ccw,
		output preview_valid, output preview_face, output preview_ccw, input ready);
	modport sink   (input valid, input action, input rotation_face, input rotation_ccw,
		input preview_valid, input preview_face, input preview_ccw, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tgc_run_counters.sv
// Per-sensor saturating signed run counters, updated once per accepted scan.
// Depends on tgc_pkg.
`default_nettype none

module tgc_run_counters import tgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      upd,
	input  sens_vec_t bits,
	output count_t    counts [NUM_SENSORS]
);

	count_t cnt_q [NUM_SENSORS];
	count_t cnt_d [NUM_SENSORS];

	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			cnt_d[i] = cnt_q[i];
			if (bits[i]) begin
				if (cnt_q[i] <= 8'sd0) begin
					cnt_d[i] = RUN_UP;
				end else if (cnt_q[i] < RUN_MAX) begin
					cnt_d[i] = cnt_q[i] + RUN_UP;
				end
			end else begin
				if (cnt_q[i] >= 8'sd0) begin
					cnt_d[i] = RUN_DN;
				end else if (cnt_q[i] > RUN_MIN) begin
					cnt_d[i] = cnt_q[i] - RUN_UP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (upd) begin
			cnt_q <= cnt_d;
		end
	end

	assign counts = cnt_q;

endmodule

`default_nettype wire

// File: rtl/core/tgc_classify.sv
// Gesture decode from the run counts: reset/scramble face, undo corner, rotation, preview.
// Depends on tgc_pkg (sensor tables, find_rotation).
`default_nettype none

module tgc_classify import tgc_pkg::*; (
	input  count_t  counts [NUM_SENSORS],
	input  thr_t    det_thr,
	input  thr_t    pre_thr,
	output result_t res
);

	count_t    det_s;
	count_t    pre_s;
	sens_vec_t det_hit;
	sens_vec_t pre_hit;
	logic [NUM_RESET_FACES-1:0] face_all;
	logic [NUM_CORNERS-1:0]     corner_all;
	rot_t      det_rot;
	rot_t      pre_rot;

	assign det_s = count_t'({1'b0, det_thr});
	assign pre_s = count_t'({1'b0, pre_thr});

	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			det_hit[i] = counts[i] >= det_s;
			pre_hit[i] = counts[i] >= pre_s;
		end
		for (int r = 0; r < NUM_RESET_FACES; r++) begin
			face_all[r] = 1'b1;
			for (int i = 0; i < FACE_LEN; i++) begin
				face_all[r] = face_all[r] & det_hit[FACE_SET[r][i]];
			end
		end
		for (int c = 0; c < NUM_CORNERS; c++) begin
			corner_all[c] = 1'b1;
			for (int i = 0; i < CORNER_LEN; i++) begin
				corner_all[c] = corner_all[c] & det_hit[CORNER_SET[c][i]];
			end
		end
	end

	assign det_rot = find_rotation(det_hit);
	assign pre_rot = find_rotation(pre_hit);

	always_comb begin
		res = '0;
		if (face_all[0]) begin
			res.action = ACT_RESET;
		end else if (face_all[1]) begin
			res.action = ACT_SCRAMBLE;
		end else if (corner_all != '0) begin
			res.action = ACT_UNDO;
		end else if (det_rot.hit) begin
			res.action   = ACT_ROTATE;
			res.rot_face = det_rot.face;
			res.rot_ccw  = det_rot.ccw;
		end else begin
			res.action = ACT_NONE;
		end
		res.pre_valid = pre_rot.hit;
		res.pre_face  = pre_rot.face;
		res.pre_ccw   = pre_rot.ccw;
	end

endmodule

`default_nettype wire

// File: rtl/core/touch_gesture_classifier.sv
// Touch gesture classifier top level: threshold registers, counter stage, result register.
// Depends on tgc_pkg, tgc_stream_if, tgc_run_counters, tgc_classify and the macro header.
//
//  channel  | role  | payload                                   | beat
//  ---------+-------+-------------------------------------------+--------------------
//  scan     | sink  | sensor_bits[23:0]                         | valid & ready
//  result   | src   | action, rotation_face/ccw, preview_*      | valid & ready
//  cfg      | write | cfg_idx (0 detect, 1 preview), cfg_data   | cfg_we
//
// One scan per cycle while scan.ready is high.
// Counters update at the scan beat; decode runs from the counters into the result register.
// Reset: counts zero, detect threshold 30, preview threshold 1, no beats pending.
// A stalled result holds; one more scan is taken into the counter stage behind it.
`default_nettype none
`include "touch_gesture_classifier_macros.svh"

module touch_gesture_classifier import tgc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  regi_t         cfg_idx,
	input  thr_t          cfg_data,
	tgc_scan_if.sink      scan,
	tgc_result_if.source  result
);

	thr_t    det_thr_q;
	thr_t    pre_thr_q;
	logic    item_v_s1;
	logic    out_v_q;
	result_t out_q;
	result_t res;
	count_t  counts [NUM_SENSORS];
	logic    in_beat;
	logic    out_free;
	logic    adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_thr_q <= THR_RESET;
			pre_thr_q <= PREVIEW_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DETECT_THR:  det_thr_q <= cfg_data;
				REG_PREVIEW_THR: pre_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free   = !out_v_q || result.ready;
	assign adv_s1     = item_v_s1 && out_free;
	assign scan.ready = !item_v_s1 || out_free;
	assign in_beat    = scan.valid && scan.ready;

	tgc_run_counters u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (in_beat),
		.bits   (scan.sensor_bits),
		.counts (counts)
	);

	tgc_classify u_cls (
		.counts  (counts),
		.det_thr (det_thr_q),
		.pre_thr (pre_thr_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (scan.ready) begin
				item_v_s1 <= scan.valid;
			end
			if (out_free) begin
				out_v_q <= item_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_v_q;
	assign result.action        = out_q.action;
	assign result.rotation_face = out_q.rot_face;
	assign result.rotation_ccw  = out_q.rot_ccw;
	assign result.preview_valid = out_q.pre_valid;
	assign result.preview_face  = out_q.pre_face;
	assign result.preview_ccw   = out_q.pre_ccw;

	`TGC_ASSERT_IMPLY(a_rot_fields, clk, arst_n,
		result.valid && (out_q.action != ACT_ROTATE),
		(result.rotation_face == '0) && !result.rotation_ccw,
		"rotation fields set without a rotation")
	`TGC_ASSERT_IMPLY(a_pre_fields, clk, arst_n,
		result.valid && !result.preview_valid,
		(result.preview_face == '0) && !result.preview_ccw,
		"preview fields set without a preview")
	`TGC_ASSERT_IMPLY(a_face_range, clk, arst_n, result.valid,
		(result.rotation_face < FACE_W'(NUM_FACES)) && (result.preview_face < FACE_W'(NUM_FACES)),
		"face code out of range")
	`TGC_ASSERT_NEXT(a_cnt_hold, clk, arst_n, !in_beat, $stable(counts[0]) && $stable(counts[23]),
		"run counts moved without a scan beat")
	`TGC_ASSERT_NEXT(a_stall_hold, clk, arst_n, result.valid && !result.ready,
		result.valid && $stable(out_q), "stalled result changed")

endmodule

`default_nettype wire

// File: test/tb_touch_gesture_classifier.sv
// Self-checking testbench for touch_gesture_classifier: held gestures, noise and threshold sweeps.
// Depends on tgc_pkg and the tgc_scan_if / tgc_result_if channel interfaces of the RTL.
// A scoreboard class predicts every result beat from its own run counts and sensor tables.
module tb_touch_gesture_classifier import tgc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 1000;
	localparam int NUM_PHASES = 6;

	localparam int SCAN_RING [6][8] = '{
		'{1, 0, 6, 7, 22, 23, 14, 15},
		'{18, 19, 4, 6, 8, 9, 15, 13},
		'{19, 17, 21, 22, 11, 8, 0, 2},
		'{17, 16, 12, 14, 10, 11, 7, 5},
		'{16, 18, 3, 1, 9, 10, 23, 20},
		'{20, 21, 5, 4, 2, 3, 13, 12}
	};
	localparam int UNDO_CORNER [8][3] = '{
		'{10, 23, 14}, '{11, 7, 22}, '{9, 15, 1}, '{8, 0, 6},
		'{18, 3, 13}, '{19, 4, 2}, '{16, 12, 20}, '{17, 21, 5}
	};
	localparam int CLEAR_FACE [2][4] = '{
		'{14, 15, 12, 13},
		'{1, 0, 3, 2}
	};
	localparam logic [7:0] TURN_PAT [4] = '{8'h11, 8'h44, 8'h22, 8'h88};

	localparam thr_t DET_SET [NUM_PHASES] = '{7'd5, 7'd0, 7'd127, 7'd1, 7'd30, 7'd12};
	localparam thr_t PRE_SET [NUM_PHASES] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd3, 7'd2};

	class gesture_scoreboard;
		int      run_len [NUM_SENSORS];
		int      detect_thr;
		int      preview_thr;
		result_t expected_q [$];
		int      errors;
		int      results;
		int      act_count [5];
		int      preview_count;

		function new();
			foreach (run_len[i])
				run_len[i] = 0;
			foreach (act_count[i])
				act_count[i] = 0;
			detect_thr    = 30;
			preview_thr   = 1;
			errors        = 0;
			results       = 0;
			preview_count = 0;
		endfunction

		function void set_threshold(regi_t idx, thr_t val);
			if (idx == REG_DETECT_THR) begin
				detect_thr = val;
			end else begin
				preview_thr = val;
			end
		endfunction

		function bit at_least(int s, int thr);
			return run_len[s] >= thr;
		endfunction

		// exactly one face ring must show an opposite-pair pattern
		function bit ring_match(int thr, output face_t face, output logic ccw);
			int         hits;
			logic [7:0] pat;
			hits = 0;
			face = '0;
			ccw  = 1'b0;
			for (int f = 0; f < 6; f++) begin
				for (int i = 0; i < 8; i++)
					pat[i] = at_least(SCAN_RING[f][i], thr);
				if (pat == 8'h11 || pat == 8'h44) begin
					hits++;
					face = face_t'(f);
					ccw  = 1'b0;
				end else if (pat == 8'h22 || pat == 8'h88) begin
					hits++;
					face = face_t'(f);
					ccw  = 1'b1;
				end
			end
			if (hits != 1) begin
				face = '0;
				ccw  = 1'b0;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_scan(sens_vec_t bits);
			result_t r;
			bit      all_on;
			face_t   f;
			logic    c;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (bits[i]) begin
					if (run_len[i] <= 0)
						run_len[i] = 1;
					else if (run_len[i] < 127)
						run_len[i]++;
				end else begin
					if (run_len[i] >= 0)
						run_len[i] = -1;
					else if (run_len[i] > -128)
						run_len[i]--;
				end
			end
			r = '0;
			r.action = ACT_NONE;
			for (int k = 0; k < 2 && r.action == ACT_NONE; k++) begin
				all_on = 1'b1;
				for (int i = 0; i < 4; i++)
					if (!at_least(CLEAR_FACE[k][i], detect_thr))
						all_on = 1'b0;
				if (all_on)
					r.action = (k == 0) ? ACT_RESET : ACT_SCRAMBLE;
			end
			for (int k = 0; k < 8 && r.action == ACT_NONE; k++) begin
				all_on = 1'b1;
				for (int i = 0; i < 3; i++)
					if (!at_least(UNDO_CORNER[k][i], detect_thr))
						all_on = 1'b0;
				if (all_on)
					r.action = ACT_UNDO;
			end
			if (r.action == ACT_NONE && ring_match(detect_thr, f, c)) begin
				r.action   = ACT_ROTATE;
				r.rot_face = f;
				r.rot_ccw  = c;
			end
			r.pre_valid = ring_match(preview_thr, f, c);
			r.pre_face  = f;
			r.pre_ccw   = c;
			expected_q.push_back(r);
		endfunction

		function void cmp_field(string name, int unsigned want, logic [2:0] got);
			if (got !== 3'(want)) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [2:0] act, face_t rf, logic rc, logic pv, face_t pf,
				logic pc);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with no scan outstanding");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			results++;
			act_count[e.action]++;
			if (e.pre_valid)
				preview_count++;
			cmp_field("action", e.action, act);
			cmp_field("rotation_face", e.rot_face, rf);
			cmp_field("rotation_ccw", e.rot_ccw, {2'b0, rc});
			cmp_field("preview_valid", e.pre_valid, {2'b0, pv});
			cmp_field("preview_face", e.pre_face, pf);
			cmp_field("preview_ccw", e.pre_ccw, {2'b0, pc});
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	regi_t cfg_idx;
	thr_t  cfg_data;

	tgc_scan_if   scan_ch ();
	tgc_result_if res_ch ();

	touch_gesture_classifier DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.scan    (scan_ch),
		.result  (res_ch)
	);

	gesture_scoreboard sb;
	int        src_idle_pct;
	int        sink_stall_pct;
	int        cur_det;
	int        quiet_cycles;
	sens_vec_t hold_mask;
	int        hold_left;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (scan_ch.valid && scan_ch.ready)
				sb.note_scan(scan_ch.sensor_bits);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.action, res_ch.rotation_face, res_ch.rotation_ccw,
					res_ch.preview_valid, res_ch.preview_face, res_ch.preview_ccw);
			if ((scan_ch.valid && scan_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic sens_vec_t ring_mask(int f, logic [7:0] pat);
		sens_vec_t m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (pat[i])
				m[SCAN_RING[f][i]] = 1'b1;
		return m;
	endfunction

	function automatic sens_vec_t clear_mask(int k);
		sens_vec_t m;
		m = '0;
		for (int i = 0; i < 4; i++)
			m[CLEAR_FACE[k][i]] = 1'b1;
		return m;
	endfunction

	function automatic sens_vec_t corner_mask(int k);
		sens_vec_t m;
		m = '0;
		for (int i = 0; i < 3; i++)
			m[UNDO_CORNER[k][i]] = 1'b1;
		return m;
	endfunction

	function automatic sens_vec_t gesture_mask();
		sens_vec_t m;
		case ($urandom_range(5))
			0: m = clear_mask($urandom_range(1));
			1: m = corner_mask($urandom_range(7));
			2, 3: m = ring_mask($urandom_range(5), TURN_PAT[$urandom_range(3)]);
			4: m = ring_mask($urandom_range(5), TURN_PAT[$urandom_range(3)])
				| ring_mask($urandom_range(5), TURN_PAT[$urandom_range(3)]);
			default: begin
				m = ring_mask($urandom_range(5), TURN_PAT[$urandom_range(3)]);
				m[$urandom_range(NUM_SENSORS - 1)] = 1'b1;
			end
		endcase
		return m;
	endfunction

	// mostly held gestures with random content, some pure noise and broken holds
	function automatic sens_vec_t next_scan();
		sens_vec_t s;
		int        short_max;
		if (hold_left == 0) begin
			if ($urandom_range(3) == 0)
				return sens_vec_t'($urandom);
			hold_mask = gesture_mask();
			short_max = (cur_det < 20 ? cur_det : 20) + 3;
			if ($urandom_range(5) == 0)
				hold_left = cur_det + $urandom_range(1, 12);
			else
				hold_left = $urandom_range(1, short_max);
		end
		hold_left--;
		s = hold_mask;
		if ($urandom_range(9) == 0)
			s[$urandom_range(NUM_SENSORS - 1)] ^= 1'b1;
		return s;
	endfunction

	task automatic send_scan(input sens_vec_t bits);
		while ($urandom_range(99) < src_idle_pct) begin
			scan_ch.valid       <= 1'b0;
			scan_ch.sensor_bits <= sens_vec_t'($urandom);
			@(negedge clk);
		end
		scan_ch.valid       <= 1'b1;
		scan_ch.sensor_bits <= bits;
		@(posedge clk);
		while (!scan_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		scan_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input regi_t idx, input thr_t val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		sb.set_threshold(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		sens_vec_t opening [$];
		int        budget;
		sb                  = new();
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_idx             = REG_DETECT_THR;
		cfg_data            = '0;
		scan_ch.valid       = 1'b0;
		scan_ch.sensor_bits = '0;
		src_idle_pct        = 0;
		sink_stall_pct      = 0;
		quiet_cycles        = 0;
		hold_mask           = '0;
		hold_left           = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_DETECT_THR, 7'd2);
		write_reg(REG_PREVIEW_THR, 7'd1);
		cur_det = 2;
		opening = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hAAAAAA, 24'h555555};
		for (int k = 0; k < 2; k++) begin
			opening.push_back(clear_mask(k));
			opening.push_back(clear_mask(k));
		end
		opening.push_back(corner_mask(0));
		opening.push_back(corner_mask(0));
		opening.push_back(ring_mask(0, 8'h11));
		opening.push_back(ring_mask(0, 8'h11));
		opening.push_back(ring_mask(2, 8'h88));
		opening.push_back(ring_mask(2, 8'h88));
		opening.push_back(ring_mask(1, 8'h22) | ring_mask(4, 8'h44));
		opening.push_back(ring_mask(1, 8'h22) | ring_mask(4, 8'h44));
		opening.push_back(ring_mask(5, 8'h44));
		opening.push_back(24'h000000);
		opening.push_back(ring_mask(3, 8'h22) | clear_mask(0));
		opening.push_back(ring_mask(3, 8'h22) | clear_mask(0));
		foreach (opening[i])
			send_scan(opening[i]);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_DETECT_THR, DET_SET[p]);
			write_reg(REG_PREVIEW_THR, PRE_SET[p]);
			cur_det   = DET_SET[p];
			hold_left = 0;
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
				default: begin src_idle_pct = 32; sink_stall_pct = 32; end
			endcase
			budget = (DET_SET[p] == 7'd127) ? 160 : 95;
			for (int n = 0; n < budget; n++)
				send_scan(next_scan());
			drain();
		end

		sink_stall_pct = 0;
		repeat (8) @(negedge clk);
		$display("Checked %0d scan results over %0d threshold settings and four idle mixes",
			sb.results, NUM_PHASES + 1);
		$display("Actions seen: none %0d, reset %0d, scramble %0d, undo %0d, rotate %0d; previews %0d",
			sb.act_count[ACT_NONE], sb.act_count[ACT_RESET], sb.act_count[ACT_SCRAMBLE],
			sb.act_count[ACT_UNDO], sb.act_count[ACT_ROTATE], sb.preview_count);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
